// File: design/trdm_pkg.sv
package trdm_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 128;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  // Field widths
  localparam int LEN_W    = 14;
  localparam int ADDR_W   = 64;
  localparam int WORD_W   = LEN_W + 1;
  localparam int STATUS_W = 3;

  // Descriptor word layout: length in the low bits, generation above it
  localparam int GEN_BIT = LEN_W;

  // Last slot of the ring, used for the wrap test
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  typedef enum logic {
    CMD_SEND  = 1'b0,
    CMD_COMPL = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOT_RUN  = 3'd1,
    ST_ZERO_LEN = 3'd2,
    ST_FULL     = 3'd3,
    ST_STALE    = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [LEN_W-1:0]  frame_length;
    logic [ADDR_W-1:0] buffer_address;
    logic              comp_gen;
    logic [IDX_W-1:0]  comp_end_index;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  slot_index;
    logic [ADDR_W-1:0] desc_address;
    logic [WORD_W-1:0] desc_word;
    logic [IDX_W-1:0]  doorbell_value;
    logic [CNT_W-1:0]  freed_count;
    logic [IDX_W-1:0]  free_slots;
  } out_item_t;

  // Input register stage to the ring core
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_beat_t;

endpackage

// File: design/trdm_in_if.sv
interface trdm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [trdm_pkg::LEN_W-1:0]   frame_length;
  logic [trdm_pkg::ADDR_W-1:0]  buffer_address;
  logic                         comp_gen;
  logic [trdm_pkg::IDX_W-1:0]   comp_end_index;

  modport source (
    output valid, command, frame_length, buffer_address, comp_gen, comp_end_index,
    input  ready
  );
  modport sink (
    input  valid, command, frame_length, buffer_address, comp_gen, comp_end_index,
    output ready
  );
endinterface

// File: design/trdm_out_if.sv
interface trdm_out_if;
  logic                          valid;
  logic                          ready;
  logic [trdm_pkg::STATUS_W-1:0] status;
  logic [trdm_pkg::IDX_W-1:0]    slot_index;
  logic [trdm_pkg::ADDR_W-1:0]   desc_address;
  logic [trdm_pkg::WORD_W-1:0]   desc_word;
  logic [trdm_pkg::IDX_W-1:0]    doorbell_value;
  logic [trdm_pkg::CNT_W-1:0]    freed_count;
  logic [trdm_pkg::IDX_W-1:0]    free_slots;

  modport source (
    output valid, status, slot_index, desc_address, desc_word, doorbell_value,
           freed_count, free_slots,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, desc_address, desc_word, doorbell_value,
           freed_count, free_slots,
    output ready
  );
endinterface

// File: design/trdm_cfg_if.sv
interface trdm_cfg_if;
  logic valid;
  logic ready;
  logic link_running;

  modport source (
    output valid, link_running,
    input  ready
  );
  modport sink (
    input  valid, link_running,
    output ready
  );
endinterface

// File: design/trdm_in_stage.sv
module trdm_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  trdm_in_if.sink             in_ch,
  input  logic                take_i,
  output trdm_pkg::in_beat_t  beat_o
);

  logic               valid_r;
  logic               valid_nxt;
  trdm_pkg::in_item_t item_r;
  logic               fire;

  // Room when empty or when the held beat leaves this cycle
  assign in_ch.ready = !valid_r || take_i;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      item_r.command        <= trdm_pkg::cmd_t'(in_ch.command);
      item_r.frame_length   <= in_ch.frame_length;
      item_r.buffer_address <= in_ch.buffer_address;
      item_r.comp_gen       <= in_ch.comp_gen;
      item_r.comp_end_index <= in_ch.comp_end_index;
    end
  end

  assign beat_o.valid = valid_r;
  assign beat_o.item  = item_r;

endmodule

// File: design/trdm_core.sv
module trdm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  trdm_pkg::in_beat_t  beat_i,
  output logic                take_o,
  trdm_cfg_if.sink            cfg_ch,
  trdm_out_if.source          out_ch
);

  localparam int IDX_W = trdm_pkg::IDX_W;
  localparam int CNT_W = trdm_pkg::CNT_W;

  // Ring state
  logic [IDX_W-1:0] prod_r, prod_nxt;
  logic [IDX_W-1:0] cons_r, cons_nxt;
  logic             ring_gen_r, ring_gen_nxt;
  logic [IDX_W-1:0] cnext_r, cnext_nxt;
  logic             cgen_r, cgen_nxt;
  logic             link_r;

  logic                out_valid_r;
  trdm_pkg::out_item_t out_r, res;
  logic [IDX_W-1:0]    free_now;
  logic [IDX_W-1:0]    eop;
  logic [IDX_W-1:0]    span;
  trdm_pkg::in_item_t  it;

  // Config register, always ready
  assign cfg_ch.ready = 1'b1;

  assign take_o = beat_i.valid && (!out_valid_r || out_ch.ready);
  assign it     = beat_i.item;

  assign free_now = cons_r - prod_r - IDX_W'(1);
  // End index taken modulo the depth
  assign eop      = it.comp_end_index;
  // Slots from the consumer to the end index, less one, wrapping at the depth
  assign span     = eop - cons_r;

  // One step of the ring
  always_comb begin
    prod_nxt     = prod_r;
    cons_nxt     = cons_r;
    ring_gen_nxt = ring_gen_r;
    cnext_nxt    = cnext_r;
    cgen_nxt     = cgen_r;
    res          = '0;
    res.status   = trdm_pkg::ST_OK;
    if (it.command == trdm_pkg::CMD_SEND) begin
      if (it.frame_length == '0) begin
        res.status = trdm_pkg::ST_ZERO_LEN;
      end else if (!link_r) begin
        res.status = trdm_pkg::ST_NOT_RUN;
      end else if (free_now == '0) begin
        res.status = trdm_pkg::ST_FULL;
      end else begin
        prod_nxt = prod_r + IDX_W'(1);
        if (prod_r == trdm_pkg::LAST_SLOT) begin
          prod_nxt     = '0;
          ring_gen_nxt = !ring_gen_r;
        end
        res.slot_index     = prod_r;
        res.desc_address   = it.buffer_address;
        res.desc_word      = {ring_gen_r, it.frame_length};
        res.doorbell_value = prod_nxt;
      end
    end else begin
      if (!link_r) begin
        res.status = trdm_pkg::ST_NOT_RUN;
      end else if (it.comp_gen != cgen_r) begin
        res.status = trdm_pkg::ST_STALE;
      end else begin
        cons_nxt  = eop + IDX_W'(1);
        cnext_nxt = cnext_r + IDX_W'(1);
        if (cnext_r == trdm_pkg::LAST_SLOT) begin
          cnext_nxt = '0;
          cgen_nxt  = !cgen_r;
        end
        res.slot_index  = cons_r;
        res.freed_count = {1'b0, span} + CNT_W'(1);
      end
    end
    res.free_slots = cons_nxt - prod_nxt - IDX_W'(1);
  end

  // State, config and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r      <= '0;
      cons_r      <= '0;
      ring_gen_r  <= 1'b1;
      cnext_r     <= '0;
      cgen_r      <= 1'b1;
      link_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        link_r <= cfg_ch.link_running;
      end
      if (take_o) begin
        prod_r      <= prod_nxt;
        cons_r      <= cons_nxt;
        ring_gen_r  <= ring_gen_nxt;
        cnext_r     <= cnext_nxt;
        cgen_r      <= cgen_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.slot_index     = out_r.slot_index;
  assign out_ch.desc_address   = out_r.desc_address;
  assign out_ch.desc_word      = out_r.desc_word;
  assign out_ch.doorbell_value = out_r.doorbell_value;
  assign out_ch.freed_count    = out_r.freed_count;
  assign out_ch.free_slots     = out_r.free_slots;

  // A rejected item leaves all ring state untouched
  a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    take_o && res.status != trdm_pkg::ST_OK
    |=> $stable(prod_r) && $stable(cons_r) && $stable(cnext_r)
        && $stable(ring_gen_r) && $stable(cgen_r))
    else $error("ring state moved on a rejected item");

  // An accepted send advances the producer by one slot
  a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
    take_o && res.status == trdm_pkg::ST_OK && it.command == trdm_pkg::CMD_SEND
    |=> prod_r == $past(prod_r) + IDX_W'(1) && $stable(cons_r))
    else $error("producer did not advance on send");

  // Ring generation flips exactly when the producer wraps to zero
  a_gen_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $changed(ring_gen_r) |-> prod_r == '0 && $past(prod_r) != '0)
    else $error("ring generation changed without a wrap");

  // Freed count on the result channel never exceeds the depth
  a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.freed_count <= CNT_W'(trdm_pkg::RING_DEPTH))
    else $error("freed count beyond ring depth");

endmodule

// File: design/tx_descriptor_ring_manager_top.sv
// Transmit descriptor ring manager. Tracks the producer, consumer and
// generation bit of a transmit ring, and the next index and expected
// generation of its completion ring. Each input beat is a send request or a
// completion and yields exactly one result beat carrying a status code; a
// rejected item (link down, zero length, ring full, stale completion)
// changes no state. Throughput is one item per clock unless the result
// channel stalls. One input register is followed by the index update and
// result register in a single stage, so the next item always sees the
// state left by the last. link_running is written on the cfg channel
// (always ready) and must only change while no item is in flight.
module tx_descriptor_ring_manager_top (
  input  logic        clk,
  input  logic        rst_n,
  trdm_in_if.sink     in_ch,
  trdm_cfg_if.sink    cfg_ch,
  trdm_out_if.source  out_ch
);

  trdm_pkg::in_beat_t beat;
  logic               take;

  trdm_in_stage u_in_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .take_i (take),
    .beat_o (beat)
  );

  trdm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (beat),
    .take_o (take),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule
